### hw/rtl/cbm_pkg.sv
package cbm_pkg;

    // Access kinds on the input tuser
    localparam logic [1:0] KIND_ROM_RD  = 2'd0;
    localparam logic [1:0] KIND_CTRL_WR = 2'd1;
    localparam logic [1:0] KIND_RAM_RD  = 2'd2;
    localparam logic [1:0] KIND_RAM_WR  = 2'd3;

    // Result targets on the output tuser
    localparam logic [2:0] TGT_NONE   = 3'd0;
    localparam logic [2:0] TGT_ROM    = 3'd1;
    localparam logic [2:0] TGT_RAM_RD = 3'd2;
    localparam logic [2:0] TGT_RAM_WR = 3'd3;
    localparam logic [2:0] TGT_DATA   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROM_BANKS       = 2'd0;
    localparam logic [1:0] CFG_RAM_EIGHT_BANKS = 2'd1;
    localparam logic [1:0] CFG_HAS_CLOCK       = 2'd2;

    // Control write regions, from address bits 14:13 below 0x8000
    localparam logic [1:0] CTRL_RAM_ENABLE = 2'd0;
    localparam logic [1:0] CTRL_ROM_BANK   = 2'd1;
    localparam logic [1:0] CTRL_SELECT     = 2'd2;
    localparam logic [1:0] CTRL_LATCH      = 2'd3;

    // Clock register selects
    localparam logic [7:0] SEL_SECONDS  = 8'h08;
    localparam logic [7:0] SEL_MINUTES  = 8'h09;
    localparam logic [7:0] SEL_HOURS    = 8'h0A;
    localparam logic [7:0] SEL_DAY_LOW  = 8'h0B;
    localparam logic [7:0] SEL_DAY_HIGH = 8'h0C;

    localparam int DEF_MAX_ROM_BANKS = 128;
    localparam int ROM_BANK_BYTES    = 16384;
    localparam int ROM_OFFSET_W      = $clog2(ROM_BANK_BYTES);
    localparam int ROM_BANK_W        = 7;
    localparam int ROM_ADDR_W        = 21;
    localparam int RAM_ADDR_W        = 16;
    localparam int CLOCK_REGS        = 5;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam logic [7:0] DAY_HIGH_MASK  = 8'hC1;
    localparam logic [7:0] NO_DATA        = 8'hFF;

    localparam int IN_TDATA_W   = 24;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 56;
    localparam int OUT_TUSER_W  = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_item;

    typedef struct packed {
        logic [2:0]            target;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic [RAM_ADDR_W-1:0] ram_address;
        logic [7:0]            ram_write_data;
        logic [7:0]            read_data;
        logic                  bank_changed;
    } t_result;

    typedef struct packed {
        logic [7:0] rom_banks;
        logic       ram_eight_banks;
        logic       has_clock;
    } t_cfg;

    // Remainder by 60 of a byte: at most three compare-and-subtract steps
    function automatic logic [7:0] mod60(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd240) r = r - 8'd240;
        if (r >= 8'd120) r = r - 8'd120;
        if (r >= 8'd60)  r = r - 8'd60;
        return r;
    endfunction

    function automatic logic [7:0] mod24(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd192) r = r - 8'd192;
        if (r >= 8'd96)  r = r - 8'd96;
        if (r >= 8'd48)  r = r - 8'd48;
        if (r >= 8'd24)  r = r - 8'd24;
        return r;
    endfunction

endpackage

### hw/rtl/cbm_core.sv
module cbm_core import cbm_pkg::*; #(
    parameter int MAX_ROM_BANKS = DEF_MAX_ROM_BANKS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    input  logic    i_fire,
    output t_result o_result
);

    localparam logic [ROM_BANK_W-1:0] MAX_MASK = ROM_BANK_W'(MAX_ROM_BANKS - 1);

    logic [ROM_BANK_W-1:0] r_rom_bank,   n_rom_bank;
    logic                  r_ram_enable, n_ram_enable;
    logic [7:0]            r_select,     n_select;
    logic                  r_armed,      n_armed;
    logic [7:0]            r_live    [CLOCK_REGS];
    logic [7:0]            n_live    [CLOCK_REGS];
    logic [7:0]            r_latched [CLOCK_REGS];
    logic                  n_do_latch;

    logic [ROM_BANK_W-1:0] rom_mask;
    logic [ROM_BANK_W-1:0] nb_raw;
    logic [ROM_BANK_W-1:0] nb_masked;
    logic [ROM_BANK_W-1:0] nb_final;
    logic [ROM_BANK_W-1:0] rd_bank;
    logic [7:0]            ram_bank_top;
    logic                  in_window;
    logic                  clock_sel;
    logic [2:0]            clk_idx;
    logic [7:0]            latched_rd;
    logic [2:0]            ram_bank;
    logic                  is_read;

    assign rom_mask  = 7'(i_cfg.rom_banks - 8'd1) & MAX_MASK;
    assign nb_raw    = (i_item.write_data[6:0] == '0) ? 7'd1 : i_item.write_data[6:0];
    assign nb_masked = nb_raw & rom_mask;
    assign nb_final  = (nb_masked == '0) ? 7'd1 : nb_masked;
    assign rd_bank   = (i_item.address[15:14] == 2'b00) ? '0 : (r_rom_bank & rom_mask);

    assign ram_bank_top = i_cfg.ram_eight_banks ? 8'h07 : 8'h03;
    assign in_window    = (i_item.address[15:13] == 3'b101);
    assign clock_sel    = i_cfg.has_clock && (r_select >= SEL_SECONDS)
                          && (r_select <= SEL_DAY_HIGH);
    assign clk_idx      = r_select[2:0];
    assign latched_rd   = (clk_idx < 3'(CLOCK_REGS)) ? r_latched[clk_idx] : NO_DATA;
    assign ram_bank     = r_select[2:0] & ram_bank_top[2:0];
    assign is_read      = (i_item.kind == KIND_RAM_RD);

    always_comb begin
        o_result     = '0;
        n_rom_bank   = r_rom_bank;
        n_ram_enable = r_ram_enable;
        n_select     = r_select;
        n_armed      = r_armed;
        n_do_latch   = 1'b0;
        for (int i = 0; i < CLOCK_REGS; i++) n_live[i] = r_live[i];

        case (i_item.kind)
            KIND_ROM_RD: begin
                o_result.target      = TGT_ROM;
                o_result.rom_address = {rd_bank, i_item.address[ROM_OFFSET_W-1:0]};
            end
            KIND_CTRL_WR: begin
                if (!i_item.address[15]) begin
                    unique case (i_item.address[14:13])
                        CTRL_RAM_ENABLE: begin
                            n_ram_enable = (i_item.write_data[3:0] == RAM_ENABLE_KEY);
                        end
                        CTRL_ROM_BANK: begin
                            n_rom_bank            = nb_final;
                            o_result.bank_changed = (nb_final != r_rom_bank);
                        end
                        CTRL_SELECT: begin
                            n_select = i_item.write_data;
                        end
                        CTRL_LATCH: begin
                            if (i_item.write_data == 8'd0) begin
                                n_armed = 1'b1;
                            end else if (i_item.write_data == 8'd1 && r_armed) begin
                                n_armed    = 1'b0;
                                n_do_latch = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                if (!r_ram_enable || !in_window) begin
                    if (is_read) begin
                        o_result.target    = TGT_DATA;
                        o_result.read_data = NO_DATA;
                    end
                end else if (clock_sel) begin
                    if (is_read) begin
                        o_result.target    = TGT_DATA;
                        o_result.read_data = latched_rd;
                    end else begin
                        unique case (r_select)
                            SEL_SECONDS:  n_live[0] = mod60(i_item.write_data);
                            SEL_MINUTES:  n_live[1] = mod60(i_item.write_data);
                            SEL_HOURS:    n_live[2] = mod24(i_item.write_data);
                            SEL_DAY_LOW:  n_live[3] = i_item.write_data;
                            SEL_DAY_HIGH: n_live[4] = i_item.write_data & DAY_HIGH_MASK;
                            default: ;
                        endcase
                    end
                end else if (r_select <= ram_bank_top) begin
                    o_result.target      = is_read ? TGT_RAM_RD : TGT_RAM_WR;
                    o_result.ram_address = {ram_bank, i_item.address[12:0]};
                    if (!is_read) o_result.ram_write_data = i_item.write_data;
                end else if (is_read) begin
                    o_result.target    = TGT_DATA;
                    o_result.read_data = NO_DATA;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank   <= 7'd1;
            r_ram_enable <= 1'b0;
            r_select     <= '0;
            r_armed      <= 1'b0;
            for (int i = 0; i < CLOCK_REGS; i++) begin
                r_live[i]    <= '0;
                r_latched[i] <= '0;
            end
        end else if (i_fire) begin
            r_rom_bank   <= n_rom_bank;
            r_ram_enable <= n_ram_enable;
            r_select     <= n_select;
            r_armed      <= n_armed;
            for (int i = 0; i < CLOCK_REGS; i++) begin
                r_live[i] <= n_live[i];
                // The latch copies the clock as it stood before this item
                if (n_do_latch) r_latched[i] <= r_live[i];
            end
        end
    end

endmodule

### hw/rtl/cartridge_bank_mapper_rtc.sv
// Cartridge bank mapper with clock registers. Each input item is one CPU bus
// access (ROM read, control write, external RAM read or write); each gives
// exactly one result item with the physical ROM or RAM address to use, or a
// byte supplied by the mapper itself. One item is taken every cycle while the
// output side keeps up. An item waits in the input register while its
// mapping is worked out, and its result is loaded into the result register
// when the item moves on; the bank, select and clock state change at that
// same edge. A result that waits on the output side holds the input register,
// so the input stalls once both registers are full. Configuration is to be
// written through the plain write port only while no item is in flight; the
// block itself does not enforce this.
module cartridge_bank_mapper_rtc import cbm_pkg::*; #(
    parameter int MAX_ROM_BANKS = DEF_MAX_ROM_BANKS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // address[15:0], write_data[23:16]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // rom_address[20:0], ram_address[36:21], ram_write_data[44:37],
    // read_data[52:45], bank_changed[53], zero[55:54]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // target[2:0]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [7:0]             i_cfg_wdata
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result core_result;
    logic    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rom_banks       <= 8'd2;
            r_cfg.ram_eight_banks <= 1'b0;
            r_cfg.has_clock       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROM_BANKS:       r_cfg.rom_banks       <= i_cfg_wdata;
                CFG_RAM_EIGHT_BANKS: r_cfg.ram_eight_banks <= i_cfg_wdata[0];
                CFG_HAS_CLOCK:       r_cfg.has_clock       <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.kind       <= s_axis_tuser[1:0];
            r_item.address    <= s_axis_tdata[15:0];
            r_item.write_data <= s_axis_tdata[23:16];
        end
    end

    cbm_core #(
        .MAX_ROM_BANKS (MAX_ROM_BANKS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .i_fire   (advance),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_result <= core_result;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_result.target;
    assign m_axis_tdata  = {2'b00, r_result.bank_changed, r_result.read_data,
                            r_result.ram_write_data, r_result.ram_address,
                            r_result.rom_address};

    // A bank change comes only from a control write, which has no target
    a_bank_change_no_target : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[53]) |-> (m_axis_tuser == TGT_NONE))
        else $error("bank change reported with a target");

    // A ROM fetch carries nothing in the RAM and data fields
    a_rom_fields_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == TGT_ROM) |-> (m_axis_tdata[53:21] == '0))
        else $error("ROM fetch with stray RAM or data bits");

    // Only a RAM write carries write data
    a_wdata_only_on_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != TGT_RAM_WR) |-> (m_axis_tdata[44:37] == '0))
        else $error("write data outside a RAM write");

    // The pipeline is empty in the cycle after reset
    a_empty_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

endmodule
